@@ rtl/core/dda4_pkg.sv @@
// ----------------------------------------------------------------------------
// dda4_pkg
// Shared types and constants of the four-axis DDA step generator.
// ----------------------------------------------------------------------------
package dda4_pkg;

  localparam int AXES      = 4;
  localparam int PERIOD_W  = 24;
  localparam int PW_W      = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam logic [PW_W-1:0] PULSE_WIDTH_RESET = 8'd2;

  localparam logic [CFG_IDX_W-1:0] REG_INVERT_DIRS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH = 2'd1;

  typedef enum logic [0:0] {
    ACT_PUSH = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef struct packed {
    logic            accepted;
    logic [AXES-1:0] pins;
    logic [AXES-1:0] dir_levels;
    logic            busy_res;
    logic            segment_done;
  } res_t;

endpackage

@@ rtl/core/dda4_ifs.sv @@
// ----------------------------------------------------------------------------
// dda4 channel interfaces
// Segment/tick input channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface dda4_in_if #(
  parameter int COUNT_BITS = 24
);
  import dda4_pkg::*;

  logic                  valid;
  logic                  ready;
  action_t               action;
  logic [COUNT_BITS-1:0] count_x;
  logic [COUNT_BITS-1:0] count_y;
  logic [COUNT_BITS-1:0] count_z;
  logic [COUNT_BITS-1:0] count_e;
  logic [AXES-1:0]       neg_mask;
  logic [PERIOD_W-1:0]   period_ticks;

  modport source (output valid, action, count_x, count_y, count_z, count_e, neg_mask,
                  period_ticks, input ready);
  modport sink (input valid, action, count_x, count_y, count_z, count_e, neg_mask,
                period_ticks, output ready);
endinterface

interface dda4_out_if;
  import dda4_pkg::*;

  logic            valid;
  logic            ready;
  logic            accepted;
  logic            pin_x;
  logic            pin_y;
  logic            pin_z;
  logic            pin_e;
  logic [AXES-1:0] dir_levels;
  logic            busy_res;
  logic            segment_done;

  modport source (output valid, accepted, pin_x, pin_y, pin_z, pin_e, dir_levels, busy_res,
                  segment_done, input ready);
  modport sink (input valid, accepted, pin_x, pin_y, pin_z, pin_e, dir_levels, busy_res,
                segment_done, output ready);
endinterface

interface dda4_cfg_if;
  import dda4_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/four_axis_dda_step_generator_unit.sv @@
// ----------------------------------------------------------------------------
// four_axis_dda_step_generator_unit
// Segment queue feeding a four-axis DDA step generator with step pulse timing.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat contents
//  in_ch    in   action, four step counts, neg_mask, period_ticks
//  out_ch   out  accepted, four step pins, dir_levels, busy_res, segment_done
//  cfg_ch   in   register index and write data, always ready
//
//  Each beat passes an input register and then a result register before
//  its result is offered; one beat is taken per cycle unless a result stalls.
//  Queued segments sit in a memory with a prefetched head register, so a
//  finishing segment is replaced in the same cycle. Reset is synchronous and
//  active low. A stalled result holds its register and the input stage backs up.
// ----------------------------------------------------------------------------
module four_axis_dda_step_generator_unit #(
  parameter int FIFO_DEPTH = 16,
  parameter int COUNT_BITS = 24
) (
  input logic      clk,
  input logic      rst_n,
  dda4_in_if.sink  in_ch,
  dda4_out_if.source out_ch,
  dda4_cfg_if.sink cfg_ch
);
  import dda4_pkg::*;

  localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [FILL_W-1:0] DEPTH_F  = FILL_W'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(FIFO_DEPTH - 1);

  typedef logic [AXES-1:0][COUNT_BITS-1:0] cnt_vec_t;

  typedef struct packed {
    logic [FILL_W-1:0]     zpre;
    logic [COUNT_BITS-1:0] total;
    logic [AXES-1:0]       neg;
    logic [PERIOD_W-1:0]   period;
    cnt_vec_t              cnt;
  } seg_t;

  // Configuration registers.
  logic [AXES-1:0] inv_r;
  logic [PW_W-1:0] pw_r;

  // Input stage.
  logic                s1_vld_r;
  action_t             s1_act_r;
  cnt_vec_t            s1_cnt_r;
  logic [AXES-1:0]     s1_neg_r;
  logic [PERIOD_W-1:0] s1_per_r;

  // Result stage.
  logic out_vld_r;
  res_t res_r, res_nxt;

  // Generator state.
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [FILL_W-1:0]     tz_r, tz_nxt;
  cnt_vec_t              cnt_r, cnt_nxt;
  cnt_vec_t              acc_r, acc_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  logic [COUNT_BITS-1:0] remain_r, remain_nxt;
  logic [PERIOD_W-1:0]   aper_r, aper_nxt;
  logic [PERIOD_W-1:0]   pcnt_r, pcnt_nxt;
  logic [PW_W-1:0]       pulse_cnt_r, pulse_cnt_nxt;
  logic [AXES-1:0]       pulse_axes_r, pulse_axes_nxt;
  logic [AXES-1:0]       dirs_r, dirs_nxt;
  logic                  run_r, run_nxt;

  // Segment queue.
  seg_t              mem [FIFO_DEPTH];
  seg_t              head_r;
  logic              head_vld_r, head_vld_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FILL_W-1:0] mcnt_r, mcnt_nxt;

  logic advance, go;
  logic enq, consume, refill, to_head, mem_we;
  logic load_en;
  seg_t in_seg, load_seg;
  logic [COUNT_BITS-1:0] max01, max23;
  logic [PERIOD_W-1:0]   min_per, load_per;
  logic [COUNT_BITS:0]   sum;
  logic [AXES-1:0]       steps;

  assign advance      = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = !s1_vld_r || advance;
  assign go           = s1_vld_r && advance;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_vld_r;
  assign out_ch.accepted     = res_r.accepted;
  assign out_ch.pin_x        = res_r.pins[0];
  assign out_ch.pin_y        = res_r.pins[1];
  assign out_ch.pin_z        = res_r.pins[2];
  assign out_ch.pin_e        = res_r.pins[3];
  assign out_ch.dir_levels   = res_r.dir_levels;
  assign out_ch.busy_res     = res_r.busy_res;
  assign out_ch.segment_done = res_r.segment_done;

  always_comb begin
    max01 = (s1_cnt_r[0] > s1_cnt_r[1]) ? s1_cnt_r[0] : s1_cnt_r[1];
    max23 = (s1_cnt_r[2] > s1_cnt_r[3]) ? s1_cnt_r[2] : s1_cnt_r[3];
    in_seg.cnt    = s1_cnt_r;
    in_seg.neg    = s1_neg_r;
    in_seg.period = s1_per_r;
    in_seg.zpre   = tz_r;
    in_seg.total  = (max01 > max23) ? max01 : max23;
  end

  always_comb begin
    fill_nxt       = fill_r;
    tz_nxt         = tz_r;
    cnt_nxt        = cnt_r;
    acc_nxt        = acc_r;
    total_nxt      = total_r;
    remain_nxt     = remain_r;
    aper_nxt       = aper_r;
    pcnt_nxt       = pcnt_r;
    pulse_cnt_nxt  = pulse_cnt_r;
    pulse_axes_nxt = pulse_axes_r;
    dirs_nxt       = dirs_r;
    run_nxt        = run_r;
    enq            = 1'b0;
    consume        = 1'b0;
    load_en        = 1'b0;
    load_seg       = in_seg;
    steps          = '0;
    sum            = '0;
    res_nxt        = '0;

    if (go) begin
      if (s1_act_r == ACT_PUSH) begin
        if (fill_r < DEPTH_F) begin
          res_nxt.accepted = 1'b1;
          if (!run_r) begin
            load_en = (in_seg.total != '0);
          end else begin
            fill_nxt = fill_r + FILL_W'(1);
            if (in_seg.total != '0) begin
              enq    = 1'b1;
              tz_nxt = '0;
            end else begin
              tz_nxt = tz_r + FILL_W'(1);
            end
          end
        end
      end else begin
        if (pulse_cnt_r != '0) begin
          pulse_cnt_nxt = pulse_cnt_r - PW_W'(1);
          if (pulse_cnt_nxt == '0) begin
            pulse_axes_nxt = '0;
          end
        end
        if (run_r) begin
          if (pcnt_r > PERIOD_W'(1)) begin
            pcnt_nxt = pcnt_r - PERIOD_W'(1);
          end else begin
            for (int a = 0; a < AXES; a++) begin
              sum = {1'b0, acc_r[a]} + {1'b0, cnt_r[a]};
              if (sum >= {1'b0, total_r}) begin
                sum      = sum - {1'b0, total_r};
                steps[a] = 1'b1;
              end
              acc_nxt[a] = sum[COUNT_BITS-1:0];
            end
            if (steps != '0) begin
              pulse_cnt_nxt  = pw_r;
              pulse_axes_nxt = (pw_r == '0) ? '0 : steps;
            end
            pcnt_nxt = aper_r;
            if (remain_r != '0) begin
              remain_nxt = remain_r - COUNT_BITS'(1);
            end
            if (remain_nxt == '0) begin
              res_nxt.segment_done = 1'b1;
              run_nxt              = 1'b0;
              if (head_vld_r) begin
                consume  = 1'b1;
                load_en  = 1'b1;
                load_seg = head_r;
                fill_nxt = fill_r - FILL_W'(1) - head_r.zpre;
              end else begin
                fill_nxt = '0;
                tz_nxt   = '0;
              end
            end
          end
        end
      end
    end

    min_per  = PERIOD_W'(pw_r) + PERIOD_W'(1);
    load_per = (load_seg.period < min_per) ? min_per : load_seg.period;
    if (load_en) begin
      cnt_nxt    = load_seg.cnt;
      acc_nxt    = '0;
      total_nxt  = load_seg.total;
      remain_nxt = load_seg.total;
      aper_nxt   = load_per;
      pcnt_nxt   = load_per;
      dirs_nxt   = ~load_seg.neg;
      run_nxt    = 1'b1;
    end

    res_nxt.pins       = (pulse_cnt_nxt != '0) ? pulse_axes_nxt : '0;
    res_nxt.dir_levels = dirs_nxt ^ inv_r;
    res_nxt.busy_res   = run_nxt || (fill_nxt != '0);
  end

  always_comb begin
    refill       = (mcnt_r != '0) && (!head_vld_r || consume);
    to_head      = enq && (mcnt_r == '0) && (!head_vld_r || consume);
    mem_we       = enq && !to_head;
    head_vld_nxt = head_vld_r;
    if (refill || to_head) begin
      head_vld_nxt = 1'b1;
    end else if (consume) begin
      head_vld_nxt = 1'b0;
    end
    mcnt_nxt = mcnt_r + FILL_W'(mem_we) - FILL_W'(refill);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr_r] <= in_seg;
    end
    if (refill) begin
      head_r <= mem[rd_ptr_r];
    end else if (to_head) begin
      head_r <= in_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_act_r    <= in_ch.action;
      s1_cnt_r[0] <= in_ch.count_x;
      s1_cnt_r[1] <= in_ch.count_y;
      s1_cnt_r[2] <= in_ch.count_z;
      s1_cnt_r[3] <= in_ch.count_e;
      s1_neg_r    <= in_ch.neg_mask;
      s1_per_r    <= in_ch.period_ticks;
    end
    if (go) begin
      res_r <= res_nxt;
    end
    cnt_r   <= cnt_nxt;
    acc_r   <= acc_nxt;
    total_r <= total_nxt;
    aper_r  <= aper_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r        <= '0;
      pw_r         <= PULSE_WIDTH_RESET;
      s1_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      fill_r       <= '0;
      tz_r         <= '0;
      remain_r     <= '0;
      pcnt_r       <= '0;
      pulse_cnt_r  <= '0;
      pulse_axes_r <= '0;
      dirs_r       <= '0;
      run_r        <= 1'b0;
      head_vld_r   <= 1'b0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      mcnt_r       <= '0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_INVERT_DIRS: inv_r <= cfg_ch.data[AXES-1:0];
          REG_PULSE_WIDTH: pw_r  <= cfg_ch.data[PW_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.ready) begin
        s1_vld_r <= in_ch.valid;
      end
      if (advance) begin
        out_vld_r <= go;
      end
      fill_r       <= fill_nxt;
      tz_r         <= tz_nxt;
      remain_r     <= remain_nxt;
      pcnt_r       <= pcnt_nxt;
      pulse_cnt_r  <= pulse_cnt_nxt;
      pulse_axes_r <= pulse_axes_nxt;
      dirs_r       <= dirs_nxt;
      run_r        <= run_nxt;
      head_vld_r   <= head_vld_nxt;
      mcnt_r       <= mcnt_nxt;
      if (mem_we) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (refill) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/dda4_checker.sv @@
// ----------------------------------------------------------------------------
// dda4_checker
// Port-level checks of the step generator, bound to the top level.
// ----------------------------------------------------------------------------
module dda4_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       accepted,
  input logic       segment_done,
  input logic [6:0] out_bits
);

  logic [1:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_no_result_without_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result shown without a pending input beat");

  a_push_never_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(accepted && segment_done))
    else $error("a push beat reported a finished segment");

  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bits) && $stable(accepted))
    else $error("stalled result changed");

endmodule

bind four_axis_dda_step_generator_unit dda4_checker u_dda4_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .accepted     (out_ch.accepted),
  .segment_done (out_ch.segment_done),
  .out_bits     ({out_ch.pin_x, out_ch.pin_y, out_ch.pin_z, out_ch.pin_e,
                  out_ch.busy_res, out_ch.dir_levels[1:0]})
);
